@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Property forms for the fractional delay comb filter assertions.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FDCF_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("fdcf assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define FDCF_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("fdcf assertion failed");

`endif

@@ sv/fdcf_pkg.sv @@
// ----------------------------------------------------------------------------
// fdcf_pkg
// Types, constants and helpers shared by the comb filter modules.
// ----------------------------------------------------------------------------
package fdcf_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int CH_BITS     = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 29;
    localparam int DELAY_W     = 29;
    localparam int GAIN_W      = 16;
    localparam int MIX_W       = 17;
    localparam int CC_W        = 4;
    localparam int FRAMES_W    = 16;
    localparam int FRAC_BITS   = 16;
    localparam int RAMP_W      = 30;
    localparam int STEP_W      = 31;
    localparam int SUM_W       = 28;

    localparam logic [DELAY_W-1:0] DELAY_MIN = 29'd131072;
    localparam logic [MIX_W-1:0]   MIX_FULL  = 17'd65536;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DELAY_TARGET  = 3'd0,
        CFG_FEEDBACK_GAIN = 3'd1,
        CFG_WET_MIX       = 3'd2,
        CFG_COMB_TYPE     = 3'd3,
        CFG_CHANNEL_COUNT = 3'd4,
        CFG_RAMP_FRAMES   = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_in;
        logic [CH_BITS-1:0]            channel;
    } t_in;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_out;
        logic [CH_BITS-1:0]            channel_out;
    } t_out;

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_CLEAR, S_RAMP, S_DIV, S_ADDR, S_RD_NEW, S_RD_OLD,
        S_INTERP, S_DELAY, S_GAIN, S_WET, S_STORE, S_MIX, S_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic pass_load;
        logic clear_step;
        logic ramp_apply;
        logic addr_calc;
        logic rd_new;
        logic rd_old;
        logic interp;
        logic delay_sum;
        logic gain_mul;
        logic wet_calc;
        logic store;
        logic mix_calc;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic pass;
        logic need_clear;
        logic clear_done;
        logic retarget;
        logic div_done;
        logic out_free;
    } t_status;

    // Saturate a widened sum to the sample range.
    function automatic logic signed [SAMPLE_BITS-1:0] sat(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = SUM_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
        lo = -hi - SUM_W'(1);
        if (v > hi) begin
            return hi[SAMPLE_BITS-1:0];
        end else if (v < lo) begin
            return lo[SAMPLE_BITS-1:0];
        end
        return v[SAMPLE_BITS-1:0];
    endfunction

endpackage

@@ sv/fractional_delay_comb_filter.sv @@
// ----------------------------------------------------------------------------
// fractional_delay_comb_filter
// Per-channel comb filter with a linearly interpolated, gliding delay.
// ----------------------------------------------------------------------------
//  Channel   Signals                                   Beat contents
//  input     i_in_valid / o_in_ready / i_in_data       sample_in, channel
//  output    o_out_valid / i_out_ready / o_out_data    sample_out, channel_out
//  config    i_cfg_we / i_cfg_idx / i_cfg_data         one register write
//
// A processed beat is checked and its glide applied, then the sequencer walks
// the tap addresses, two store reads, three multiplies and the store write one
// step per cycle to the output register. A beat that passes through unchanged
// goes from the check straight to the output step. A new delay target adds a
// wait on the bit-serial step divider. The first processed beat after reset or
// after a channel-count change first clears the store, one entry per cycle, all
// MAX_CHANNELS * MAX_DELAY entries. One beat is in flight at a time; a result
// waits in the sequencer's final step until the stalled output is free.
// ----------------------------------------------------------------------------
module fractional_delay_comb_filter #(
    parameter int MAX_DELAY    = 4096,
    parameter int MAX_CHANNELS = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  fdcf_pkg::t_in                     i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output fdcf_pkg::t_out                    o_out_data,
    input  logic                              i_cfg_we,
    input  logic [fdcf_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [fdcf_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    // Commands flow from the sequencer to the datapath, status flows back.
    fdcf_pkg::t_cmd    cmd;
    fdcf_pkg::t_status status;

    fdcf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // The datapath owns the configuration registers, the delay store, the
    // glide state and the output register.
    fdcf_datapath #(
        .MAX_DELAY    (MAX_DELAY),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

@@ sv/fdcf_div.sv @@
// ----------------------------------------------------------------------------
// fdcf_div
// Bit-serial signed by unsigned divider for the delay glide step.
// ----------------------------------------------------------------------------
module fdcf_div (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic signed [fdcf_pkg::STEP_W-1:0]    i_dividend,
    input  logic [fdcf_pkg::FRAMES_W-1:0]         i_divisor,
    output logic                                  o_done,
    output logic signed [fdcf_pkg::STEP_W-1:0]    o_quotient
);

    localparam int QW = fdcf_pkg::RAMP_W;
    localparam int RW = fdcf_pkg::FRAMES_W + 1;
    localparam int CW = $clog2(QW + 1);

    logic            r_busy, n_busy;
    logic            r_done, n_done;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic [QW-1:0]   r_quo, n_quo;
    logic [RW-1:0]   r_rem, n_rem;
    logic [RW-1:0]   r_dsr, n_dsr;
    logic            r_neg, n_neg;
    logic [RW-1:0]   rem_sh;
    logic [fdcf_pkg::STEP_W-1:0] mag;

    assign mag    = i_dividend[fdcf_pkg::STEP_W-1] ? -i_dividend : i_dividend;
    assign rem_sh = {r_rem[RW-2:0], r_quo[QW-1]};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_dsr  = r_dsr;
        n_neg  = r_neg;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_quo  = mag[QW-1:0];
            n_rem  = '0;
            n_dsr  = {1'b0, i_divisor};
            n_neg  = i_dividend[fdcf_pkg::STEP_W-1];
        end else if (r_busy) begin
            if (rem_sh >= r_dsr) begin
                n_rem = rem_sh - r_dsr;
                n_quo = {r_quo[QW-2:0], 1'b1};
            end else begin
                n_rem = rem_sh;
                n_quo = {r_quo[QW-2:0], 1'b0};
            end
            n_cnt = r_cnt + CW'(1);
            if (r_cnt == CW'(QW - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dsr <= n_dsr;
        r_neg <= n_neg;
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});

endmodule

@@ sv/fdcf_datapath.sv @@
// ----------------------------------------------------------------------------
// fdcf_datapath
// Configuration, delay store, glide state, arithmetic and output register.
// ----------------------------------------------------------------------------
module fdcf_datapath #(
    parameter int MAX_DELAY    = 4096,
    parameter int MAX_CHANNELS = 8
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [fdcf_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [fdcf_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  fdcf_pkg::t_in                         i_in_data,
    input  fdcf_pkg::t_cmd                        i_cmd,
    output fdcf_pkg::t_status                     o_status,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output fdcf_pkg::t_out                        o_out_data
);

    localparam int SB    = fdcf_pkg::SAMPLE_BITS;
    localparam int AW    = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
    localparam int NW    = $clog2(MAX_DELAY + 1);
    localparam int CHW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int DEPTH = MAX_CHANNELS * MAX_DELAY;
    localparam int MW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DV_W  = 34;
    localparam int IP_W  = SB + 1 + fdcf_pkg::FRAC_BITS + 1;
    localparam int DL_W  = SB + fdcf_pkg::FRAC_BITS + 2;
    localparam int GP_W  = fdcf_pkg::GAIN_W + DL_W;
    localparam int MP_W  = fdcf_pkg::MIX_W + 1 + SB + 1;
    localparam logic [DV_W-1:0] DMAX = DV_W'(MAX_DELAY) << fdcf_pkg::FRAC_BITS;

    // Configuration registers.
    logic [fdcf_pkg::DELAY_W-1:0]         r_target;
    logic signed [fdcf_pkg::GAIN_W-1:0]   r_gain;
    logic [fdcf_pkg::MIX_W-1:0]           r_mix;
    logic                                 r_comb;
    logic [fdcf_pkg::CC_W-1:0]            r_cc;
    logic [fdcf_pkg::FRAMES_W-1:0]        r_frames;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= fdcf_pkg::DELAY_MIN;
            r_gain   <= 16'sd16384;
            r_mix    <= 17'd32768;
            r_comb   <= 1'b0;
            r_cc     <= 4'd2;
            r_frames <= 16'd240;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                fdcf_pkg::CFG_DELAY_TARGET:  r_target <= i_cfg_data[fdcf_pkg::DELAY_W-1:0];
                fdcf_pkg::CFG_FEEDBACK_GAIN: r_gain   <= i_cfg_data[fdcf_pkg::GAIN_W-1:0];
                fdcf_pkg::CFG_WET_MIX:       r_mix    <= i_cfg_data[fdcf_pkg::MIX_W-1:0];
                fdcf_pkg::CFG_COMB_TYPE:     r_comb   <= i_cfg_data[0];
                fdcf_pkg::CFG_CHANNEL_COUNT: r_cc     <= i_cfg_data[fdcf_pkg::CC_W-1:0];
                fdcf_pkg::CFG_RAMP_FRAMES:   r_frames <= i_cfg_data[fdcf_pkg::FRAMES_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Item registers and derived configuration.
    logic signed [SB-1:0]              r_x;
    logic [fdcf_pkg::CH_BITS-1:0]      r_ch;
    logic [fdcf_pkg::DELAY_W-1:0]      d_clamp;
    logic [fdcf_pkg::FRAMES_W-1:0]     frames_eff;
    logic [fdcf_pkg::MIX_W-1:0]        mix_eff;
    logic [CHW-1:0]                    ch_idx;
    logic                              frame_end;

    assign d_clamp    = (r_target < fdcf_pkg::DELAY_MIN) ? fdcf_pkg::DELAY_MIN : r_target;
    assign frames_eff = (r_frames == '0) ? fdcf_pkg::FRAMES_W'(1) : r_frames;
    assign mix_eff    = (r_mix > fdcf_pkg::MIX_FULL) ? fdcf_pkg::MIX_FULL : r_mix;
    assign ch_idx     = CHW'(r_ch);
    assign frame_end  = ({1'b0, r_ch} == (r_cc - fdcf_pkg::CC_W'(1)));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x  <= i_in_data.sample_in;
            r_ch <= i_in_data.channel;
        end
    end

    // Glide state and store housekeeping.
    logic [fdcf_pkg::RAMP_W-1:0]          r_cur, r_goal;
    logic signed [fdcf_pkg::STEP_W-1:0]   r_step;
    logic [fdcf_pkg::FRAMES_W-1:0]        r_rem;
    logic                                 r_started;
    logic [fdcf_pkg::CC_W-1:0]            r_seen;
    logic [MW-1:0]                        r_clr;
    logic [AW-1:0]                        r_wpos [MAX_CHANNELS];
    logic                                 div_done;
    logic signed [fdcf_pkg::STEP_W-1:0]   div_q;
    logic signed [fdcf_pkg::STEP_W-1:0]   div_num;
    logic                                 div_start;
    logic                                 retarget;
    logic signed [fdcf_pkg::STEP_W:0]     cur_next;

    assign retarget  = r_started && ({1'b0, d_clamp} != r_goal);
    assign div_start = i_cmd.ramp_apply && retarget;
    assign div_num   = $signed({2'b00, d_clamp}) - $signed({1'b0, r_cur});
    assign cur_next  = $signed({2'b00, r_cur})
                     + $signed({r_step[fdcf_pkg::STEP_W-1], r_step});

    fdcf_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_num),
        .i_divisor  (frames_eff),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur     <= '0;
            r_goal    <= '0;
            r_step    <= '0;
            r_rem     <= '0;
            r_started <= 1'b0;
            r_seen    <= '0;
            r_clr     <= '0;
            for (int i = 0; i < MAX_CHANNELS; i++) begin
                r_wpos[i] <= '0;
            end
        end else begin
            if (i_cmd.load) begin
                r_clr <= '0;
            end
            if (i_cmd.clear_step) begin
                r_clr <= r_clr + MW'(1);
                if (r_clr == MW'(DEPTH - 1)) begin
                    r_seen <= r_cc;
                    for (int i = 0; i < MAX_CHANNELS; i++) begin
                        r_wpos[i] <= '0;
                    end
                end
            end
            if (i_cmd.ramp_apply) begin
                if (!r_started) begin
                    r_cur     <= {1'b0, d_clamp};
                    r_goal    <= {1'b0, d_clamp};
                    r_step    <= '0;
                    r_rem     <= '0;
                    r_started <= 1'b1;
                end else if (retarget) begin
                    r_goal <= {1'b0, d_clamp};
                    r_rem  <= frames_eff;
                end
            end
            if (div_done) begin
                r_step <= div_q;
            end
            if (i_cmd.store) begin
                r_wpos[ch_idx] <= (r_wpos[ch_idx] == AW'(MAX_DELAY - 1))
                                ? '0 : r_wpos[ch_idx] + AW'(1);
            end
            if (i_cmd.mix_calc && frame_end) begin
                if (r_rem <= fdcf_pkg::FRAMES_W'(1)) begin
                    r_cur  <= r_goal;
                    r_rem  <= '0;
                    r_step <= '0;
                end else begin
                    r_cur <= cur_next[fdcf_pkg::RAMP_W-1:0];
                    r_rem <= r_rem - fdcf_pkg::FRAMES_W'(1);
                end
            end
        end
    end

    // Tap addresses from the current delay.
    logic signed [DV_W-1:0]  dv_raw;
    logic [DV_W-1:0]         dv;
    logic [NW-1:0]           n_int;
    logic [AW:0]             tap_sum;
    logic [AW-1:0]           newer, older;
    logic [AW-1:0]           r_newer, r_older, r_wp;
    logic [fdcf_pkg::FRAC_BITS-1:0] r_frac;

    always_comb begin
        if (r_rem <= fdcf_pkg::FRAMES_W'(1)) begin
            dv_raw = $signed({(DV_W - fdcf_pkg::RAMP_W)'(0), r_goal});
        end else begin
            dv_raw = DV_W'(cur_next);
        end
        if (dv_raw < 0) begin
            dv = '0;
        end else if ($unsigned(dv_raw) > DMAX) begin
            dv = DMAX;
        end else begin
            dv = $unsigned(dv_raw);
        end
    end

    assign n_int   = dv[fdcf_pkg::FRAC_BITS +: NW];
    assign tap_sum = (AW+1)'(r_wpos[ch_idx]) + (AW+1)'(MAX_DELAY) - (AW+1)'(n_int);
    assign newer   = (tap_sum >= (AW+1)'(MAX_DELAY)) ? AW'(tap_sum - (AW+1)'(MAX_DELAY))
                                                     : tap_sum[AW-1:0];
    assign older   = (newer == '0) ? AW'(MAX_DELAY - 1) : newer - AW'(1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.addr_calc) begin
            r_newer <= newer;
            r_older <= older;
            r_wp    <= r_wpos[ch_idx];
            r_frac  <= dv[fdcf_pkg::FRAC_BITS-1:0];
        end
    end

    // Delay store.
    logic [SB-1:0]  mem [DEPTH];
    logic [MW-1:0]  base, mem_raddr, mem_waddr;
    logic [SB-1:0]  mem_wdata;
    logic           mem_we;
    logic [SB-1:0]  r_rd_data;
    logic signed [SB-1:0] r_wet;

    assign base      = MW'(ch_idx) * MW'(MAX_DELAY);
    assign mem_raddr = base + MW'(i_cmd.rd_old ? r_older : r_newer);
    assign mem_we    = i_cmd.clear_step || i_cmd.store;
    assign mem_waddr = i_cmd.clear_step ? r_clr : base + MW'(r_wp);
    assign mem_wdata = i_cmd.clear_step ? '0 : (r_comb ? r_x : r_wet);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= mem[mem_raddr];
    end

    // Interpolation, gain and mix.
    logic signed [SB-1:0]   r_ns;
    logic signed [IP_W-1:0] r_iprod;
    logic signed [DL_W-1:0] r_delayed;
    logic signed [GP_W-1:0] r_gprod;
    logic signed [MP_W-1:0] r_mprod;
    logic signed [SB-1:0]   r_y;
    logic signed [SB:0]     tap_diff;
    logic signed [GP_W-1:0] g_round;
    logic signed [MP_W-1:0] m_round;
    logic signed [SB:0]     wet_diff;

    assign tap_diff = $signed({r_rd_data[SB-1], r_rd_data}) - $signed({r_ns[SB-1], r_ns});
    assign g_round  = r_gprod + (GP_W'(1) <<< 30);
    assign m_round  = r_mprod + (MP_W'(1) <<< 15);
    assign wet_diff = $signed({r_wet[SB-1], r_wet}) - $signed({r_x[SB-1], r_x});

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_old) begin
            r_ns <= r_rd_data;
        end
        if (i_cmd.interp) begin
            r_iprod <= tap_diff * $signed({1'b0, r_frac});
        end
        if (i_cmd.delay_sum) begin
            r_delayed <= (DL_W'(r_ns) <<< fdcf_pkg::FRAC_BITS) + DL_W'(r_iprod);
        end
        if (i_cmd.gain_mul) begin
            r_gprod <= GP_W'(r_gain) * GP_W'(r_delayed);
        end
        if (i_cmd.wet_calc) begin
            r_wet <= fdcf_pkg::sat(fdcf_pkg::SUM_W'(r_x)
                                   + fdcf_pkg::SUM_W'($signed(g_round[GP_W-1:31])));
        end
        if (i_cmd.store) begin
            r_mprod <= $signed({1'b0, mix_eff}) * wet_diff;
        end
        if (i_cmd.pass_load) begin
            r_y <= r_x;
        end else if (i_cmd.mix_calc) begin
            r_y <= fdcf_pkg::sat(fdcf_pkg::SUM_W'(r_x)
                                 + fdcf_pkg::SUM_W'($signed(m_round[MP_W-1:16])));
        end
    end

    // Output register.
    logic r_o_valid;
    fdcf_pkg::t_out r_o_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
        if (i_cmd.out_load) begin
            r_o_data.sample_out  <= r_y;
            r_o_data.channel_out <= r_ch;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_out_data  = r_o_data;

    // Status towards the controller.
    always_comb begin
        o_status.pass = (r_cc == '0)
                     || (32'(r_cc) > MAX_CHANNELS)
                     || ({1'b0, r_ch} >= r_cc)
                     || (32'(r_ch) >= MAX_CHANNELS)
                     || (DV_W'(d_clamp) > DMAX);
        o_status.need_clear = (r_seen != r_cc);
        o_status.clear_done = (r_clr == MW'(DEPTH - 1));
        o_status.retarget   = retarget;
        o_status.div_done   = div_done;
        o_status.out_free   = !r_o_valid || i_out_ready;
    end

endmodule

@@ sv/fdcf_ctrl.sv @@
// ----------------------------------------------------------------------------
// fdcf_ctrl
// Sequencer that steps one sample through the datapath.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fdcf_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  fdcf_pkg::t_status  i_status,
    output fdcf_pkg::t_cmd     o_cmd
);

    fdcf_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fdcf_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            fdcf_pkg::S_IDLE:   if (i_in_valid) n_state = fdcf_pkg::S_CHECK;
            fdcf_pkg::S_CHECK: begin
                if (i_status.pass) begin
                    n_state = fdcf_pkg::S_OUT;
                end else if (i_status.need_clear) begin
                    n_state = fdcf_pkg::S_CLEAR;
                end else begin
                    n_state = fdcf_pkg::S_RAMP;
                end
            end
            fdcf_pkg::S_CLEAR:  if (i_status.clear_done) n_state = fdcf_pkg::S_RAMP;
            fdcf_pkg::S_RAMP: begin
                n_state = i_status.retarget ? fdcf_pkg::S_DIV : fdcf_pkg::S_ADDR;
            end
            fdcf_pkg::S_DIV:    if (i_status.div_done) n_state = fdcf_pkg::S_ADDR;
            fdcf_pkg::S_ADDR:   n_state = fdcf_pkg::S_RD_NEW;
            fdcf_pkg::S_RD_NEW: n_state = fdcf_pkg::S_RD_OLD;
            fdcf_pkg::S_RD_OLD: n_state = fdcf_pkg::S_INTERP;
            fdcf_pkg::S_INTERP: n_state = fdcf_pkg::S_DELAY;
            fdcf_pkg::S_DELAY:  n_state = fdcf_pkg::S_GAIN;
            fdcf_pkg::S_GAIN:   n_state = fdcf_pkg::S_WET;
            fdcf_pkg::S_WET:    n_state = fdcf_pkg::S_STORE;
            fdcf_pkg::S_STORE:  n_state = fdcf_pkg::S_MIX;
            fdcf_pkg::S_MIX:    n_state = fdcf_pkg::S_OUT;
            fdcf_pkg::S_OUT:    if (i_status.out_free) n_state = fdcf_pkg::S_IDLE;
            default:            n_state = fdcf_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            fdcf_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            fdcf_pkg::S_CHECK:  o_cmd.pass_load  = i_status.pass;
            fdcf_pkg::S_CLEAR:  o_cmd.clear_step = 1'b1;
            fdcf_pkg::S_RAMP:   o_cmd.ramp_apply = 1'b1;
            fdcf_pkg::S_ADDR:   o_cmd.addr_calc  = 1'b1;
            fdcf_pkg::S_RD_NEW: o_cmd.rd_new     = 1'b1;
            fdcf_pkg::S_RD_OLD: o_cmd.rd_old     = 1'b1;
            fdcf_pkg::S_INTERP: o_cmd.interp     = 1'b1;
            fdcf_pkg::S_DELAY:  o_cmd.delay_sum  = 1'b1;
            fdcf_pkg::S_GAIN:   o_cmd.gain_mul   = 1'b1;
            fdcf_pkg::S_WET:    o_cmd.wet_calc   = 1'b1;
            fdcf_pkg::S_STORE:  o_cmd.store      = 1'b1;
            fdcf_pkg::S_MIX:    o_cmd.mix_calc   = 1'b1;
            fdcf_pkg::S_OUT:    o_cmd.out_load   = i_status.out_free;
            default: begin
            end
        endcase
    end

    `FDCF_ASSERT_NXT(a_pass_skips_work, i_clk, i_rst_n, (r_state == fdcf_pkg::S_CHECK) && i_status.pass, r_state == fdcf_pkg::S_OUT)
    `FDCF_ASSERT_NXT(a_div_waits, i_clk, i_rst_n, (r_state == fdcf_pkg::S_DIV) && !i_status.div_done, r_state == fdcf_pkg::S_DIV)
    `FDCF_ASSERT_NXT(a_out_returns_idle, i_clk, i_rst_n, (r_state == fdcf_pkg::S_OUT) && i_status.out_free, r_state == fdcf_pkg::S_IDLE)
    `FDCF_ASSERT_IMP(a_no_accept_busy, i_clk, i_rst_n, o_cmd.load, o_in_ready && (r_state == fdcf_pkg::S_IDLE))

endmodule

@@ verif/fractional_delay_comb_filter_test.sv @@
// ----------------------------------------------------------------------------
// fractional_delay_comb_filter_test
// Self-checking bench for the fractional delay comb filter. A directed table of
// beats is followed by random frames over a series of register settings. Every
// output beat is compared with a bit-accurate predictor of the filter.
// ----------------------------------------------------------------------------
module fractional_delay_comb_filter_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH    = 4096;
    localparam int NCH      = 8;
    localparam int IDLE_PCT = 16;
    // Limit on cycles with no beat moving. It has to cover the store clear after a
    // change of channel count, which writes all 32768 entries of the store.
    localparam int STALL_LIMIT = 150000;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_in_valid;
    logic                            o_in_ready;
    fdcf_pkg::t_in                   i_in_data;
    logic                            o_out_valid;
    logic                            i_out_ready;
    fdcf_pkg::t_out                  o_out_data;
    logic                            i_cfg_we;
    logic [fdcf_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [fdcf_pkg::CFG_DATA_W-1:0] i_cfg_data;

    fractional_delay_comb_filter dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Predictor copy of the registers.
    logic [fdcf_pkg::DELAY_W-1:0]         reg_delay;
    logic signed [fdcf_pkg::GAIN_W-1:0]   reg_gain;
    logic [fdcf_pkg::MIX_W-1:0]           reg_mix;
    logic                                 reg_comb;
    logic [fdcf_pkg::CC_W-1:0]            reg_chans;
    logic [fdcf_pkg::FRAMES_W-1:0]        reg_frames;

    // Predictor copy of the filter state.
    int          line_mem [NCH*DEPTH];
    int unsigned wr_pos [NCH];
    longint      glide_now, glide_goal, glide_step;
    int unsigned glide_left;
    bit          glide_started;
    int unsigned chans_seen;

    fdcf_pkg::t_out expected_out[$];
    int   fail_count;
    bit   calm;            // when set, neither side idles
    int   quiet_cycles;

    function automatic longint sat24(longint v);
        if (v > 64'sd8388607) return 64'sd8388607;
        if (v < -64'sd8388608) return -64'sd8388608;
        return v;
    endfunction

    // Round to nearest with halves towards plus infinity.
    function automatic longint rshift_round(longint v, int s);
        longint t;
        t = v + (64'sd1 <<< (s - 1));
        return t >>> s;
    endfunction

    function automatic fdcf_pkg::t_out comb_predict(fdcf_pkg::t_in beat);
        fdcf_pkg::t_out r;
        longint x, dly, dv, ns, os, delayed, wet, mixv, y;
        int unsigned ch, n, frac, wp, newer, older;
        x   = longint'(beat.sample_in);
        ch  = beat.channel;
        r.channel_out = beat.channel;
        r.sample_out  = beat.sample_in;
        dly = (reg_delay < fdcf_pkg::DELAY_MIN) ? longint'(fdcf_pkg::DELAY_MIN)
                                                : longint'(reg_delay);
        // Bad channel count, channel out of range or too long a delay: pass through.
        if (reg_chans == 0 || reg_chans > NCH || ch >= reg_chans ||
            dly > (longint'(DEPTH) << 16)) begin
            return r;
        end
        if (chans_seen != reg_chans) begin
            foreach (line_mem[i]) line_mem[i] = 0;
            foreach (wr_pos[i]) wr_pos[i] = 0;
            chans_seen = reg_chans;
        end
        if (!glide_started) begin
            glide_now = dly;
            glide_goal = dly;
            glide_step = 0;
            glide_left = 0;
            glide_started = 1'b1;
        end else if (dly != glide_goal) begin
            glide_goal = dly;
            glide_left = (reg_frames == 0) ? 1 : reg_frames;
            glide_step = (glide_goal - glide_now) / longint'(glide_left);
        end
        dv = (glide_left <= 1) ? glide_goal : glide_now + glide_step;
        if (dv < 0) dv = 0;
        if (dv > (longint'(DEPTH) << 16)) dv = longint'(DEPTH) << 16;
        n     = int'(dv >> 16);
        frac  = int'(dv & 64'hFFFF);
        wp    = wr_pos[ch] % DEPTH;
        newer = (wp + DEPTH - n) % DEPTH;
        older = (newer == 0) ? DEPTH - 1 : newer - 1;
        ns    = line_mem[ch*DEPTH + newer];
        os    = line_mem[ch*DEPTH + older];
        delayed = ns * 65536 + (os - ns) * longint'(frac);
        wet = sat24(x + rshift_round(longint'(reg_gain) * delayed, 31));
        line_mem[ch*DEPTH + wp] = int'(reg_comb ? x : wet);
        wr_pos[ch] = (wp + 1) % DEPTH;
        mixv = (reg_mix > fdcf_pkg::MIX_FULL) ? 65536 : longint'(reg_mix);
        y = sat24(x + rshift_round(mixv * (wet - x), 16));
        r.sample_out = y[fdcf_pkg::SAMPLE_BITS-1:0];
        // The last channel of a frame advances the glide.
        if (ch == reg_chans - 1) begin
            if (glide_left <= 1) begin
                glide_now = glide_goal;
                glide_left = 0;
                glide_step = 0;
            end else begin
                glide_now += glide_step;
                glide_left--;
            end
        end
        return r;
    endfunction

    // One register write; only called with the filter idle. The enable is
    // dropped again before the task returns.
    task automatic write_reg(fdcf_pkg::t_cfg_idx idx, logic [fdcf_pkg::CFG_DATA_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            fdcf_pkg::CFG_DELAY_TARGET:  reg_delay  = val[fdcf_pkg::DELAY_W-1:0];
            fdcf_pkg::CFG_FEEDBACK_GAIN: reg_gain   = val[fdcf_pkg::GAIN_W-1:0];
            fdcf_pkg::CFG_WET_MIX:       reg_mix    = val[fdcf_pkg::MIX_W-1:0];
            fdcf_pkg::CFG_COMB_TYPE:     reg_comb   = val[0];
            fdcf_pkg::CFG_CHANNEL_COUNT: reg_chans  = val[fdcf_pkg::CC_W-1:0];
            fdcf_pkg::CFG_RAMP_FRAMES:   reg_frames = val[fdcf_pkg::FRAMES_W-1:0];
            default: ;
        endcase
    endtask

    // Hold off the sender until every expected beat has come back.
    task automatic drain;
        i_in_valid <= 1'b0;
        while (expected_out.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    // Offer one input beat, with an occasional gap first, and predict it once taken.
    task automatic send_beat(fdcf_pkg::t_in beat);
        if (!calm && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= beat;
        do @(posedge i_clk); while (!o_in_ready);
        expected_out.push_back(comb_predict(beat));
    endtask

    function automatic logic [fdcf_pkg::SAMPLE_BITS-1:0] rand_sample();
        case ($urandom_range(7))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return 24'h000000;
            3: return 24'($urandom_range(0, 255)) - 24'd128;
            default: return 24'($urandom);
        endcase
    endfunction

    // Mostly small delays so that the taps land on recent beats, with the odd
    // extreme one: below two samples, the very top, and beyond the store.
    function automatic logic [fdcf_pkg::CFG_DATA_W-1:0] rand_delay();
        case ($urandom_range(9))
            0: return 29'd0;
            1: return 29'd268435456;
            2: return 29'h1FFFFFFF;
            3: return 29'd131072;
            default: return 29'($urandom_range(131072, 40 << 16));
        endcase
    endfunction

    // Output side: random stalls, and the check of every beat taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
            if (o_out_valid && i_out_ready) begin
                if (expected_out.size() == 0) begin
                    $error("output beat with nothing expected: sample %0d channel %0d",
                           o_out_data.sample_out, o_out_data.channel_out);
                    fail_count++;
                end else begin
                    fdcf_pkg::t_out want;
                    want = expected_out.pop_front();
                    if (o_out_data.sample_out !== want.sample_out) begin
                        $error("sample_out: expected %0d, got %0d",
                               want.sample_out, o_out_data.sample_out);
                        fail_count++;
                    end
                    if (o_out_data.channel_out !== want.channel_out) begin
                        $error("channel_out: expected %0d, got %0d",
                               want.channel_out, o_out_data.channel_out);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Watchdog on cycles in which no beat moves on either side.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no beat moved for %0d cycles", STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    typedef struct {
        logic [fdcf_pkg::SAMPLE_BITS-1:0] smp;
        logic [fdcf_pkg::CH_BITS-1:0]     ch;
        bit                               known;
        logic [fdcf_pkg::SAMPLE_BITS-1:0] want;
    } t_dir_row;

    t_dir_row dir_rows [18];

    // Channel count for each random phase; nine and zero are invalid and
    // must pass every beat through without disturbing the store.
    logic [fdcf_pkg::CC_W-1:0] phase_chans [8] =
        '{4'd1, 4'd8, 4'd3, 4'd9, 4'd8, 4'd2, 4'd0, 4'd5};

    initial begin
        fdcf_pkg::t_in  beat;
        fdcf_pkg::t_out got;
        int   unsigned ch;
        quiet_cycles  = 0;
        fail_count    = 0;
        calm          = 1'b0;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in_data     = '0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_data    = '0;
        reg_delay     = 29'd131072;
        reg_gain      = 16'sd16384;
        reg_mix       = 17'd32768;
        reg_comb      = 1'b0;
        reg_chans     = 4'd2;
        reg_frames    = 16'd240;
        foreach (line_mem[i]) line_mem[i] = 0;
        foreach (wr_pos[i]) wr_pos[i] = 0;
        glide_now = 0; glide_goal = 0; glide_step = 0; glide_left = 0;
        glide_started = 1'b0;
        chans_seen = 0;

        // Reset values: the store is empty, so the first beat of each channel
        // comes out unchanged, and channels beyond the count pass straight through.
        dir_rows = '{
            '{24'h7FFFFF, 3'd0, 1'b1, 24'h7FFFFF},
            '{24'h800000, 3'd1, 1'b1, 24'h800000},
            '{24'h123456, 3'd5, 1'b1, 24'h123456},
            '{24'h800000, 3'd7, 1'b1, 24'h800000},
            '{24'h7FFFFF, 3'd0, 1'b1, 24'h7FFFFF},
            '{24'h800000, 3'd1, 1'b1, 24'h800000},
            '{24'h7FFFFF, 3'd0, 1'b0, 24'h0},
            '{24'h800000, 3'd1, 1'b0, 24'h0},
            '{24'h7FFFFF, 3'd0, 1'b0, 24'h0},
            '{24'h800000, 3'd1, 1'b0, 24'h0},
            '{24'h000000, 3'd0, 1'b0, 24'h0},
            '{24'h000001, 3'd1, 1'b0, 24'h0},
            '{24'hFFFFFF, 3'd0, 1'b0, 24'h0},
            '{24'h555555, 3'd1, 1'b0, 24'h0},
            '{24'hAAAAAA, 3'd0, 1'b0, 24'h0},
            '{24'h000000, 3'd1, 1'b0, 24'h0},
            '{24'h7FFFFF, 3'd2, 1'b1, 24'h7FFFFF},
            '{24'h000000, 3'd0, 1'b0, 24'h0}
        };

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at reset values, no idling on either side.
        calm = 1'b1;
        foreach (dir_rows[r]) begin
            beat.sample_in = dir_rows[r].smp;
            beat.channel   = dir_rows[r].ch;
            send_beat(beat);
            got = expected_out[$];
            if (dir_rows[r].known && got.sample_out !== dir_rows[r].want) begin
                $error("table row %0d sample_out: expected %0d, predicted %0d",
                       r, $signed(dir_rows[r].want), got.sample_out);
                fail_count++;
            end
        end
        calm = 1'b0;

        // Random phases, every register rewritten at each.
        for (int p = 0; p < 8; p++) begin
            drain();
            write_reg(fdcf_pkg::CFG_DELAY_TARGET, rand_delay());
            case (p % 4)
                0: write_reg(fdcf_pkg::CFG_FEEDBACK_GAIN, 29'(16'h8000));
                1: write_reg(fdcf_pkg::CFG_FEEDBACK_GAIN, 29'(16'h7FFF));
                default: write_reg(fdcf_pkg::CFG_FEEDBACK_GAIN,
                                   29'($urandom_range(0, 65535)));
            endcase
            case (p % 4)
                0: write_reg(fdcf_pkg::CFG_WET_MIX, 29'd65536);
                1: write_reg(fdcf_pkg::CFG_WET_MIX, 29'd0);
                2: write_reg(fdcf_pkg::CFG_WET_MIX, 29'h1FFFF);
                default: write_reg(fdcf_pkg::CFG_WET_MIX, 29'($urandom_range(0, 65536)));
            endcase
            write_reg(fdcf_pkg::CFG_COMB_TYPE, 29'(p & 1));
            write_reg(fdcf_pkg::CFG_CHANNEL_COUNT, 29'(phase_chans[p]));
            case (p)
                1: write_reg(fdcf_pkg::CFG_RAMP_FRAMES, 29'd65535);
                4: write_reg(fdcf_pkg::CFG_RAMP_FRAMES, 29'd0);
                5: write_reg(fdcf_pkg::CFG_RAMP_FRAMES, 29'd1);
                default: write_reg(fdcf_pkg::CFG_RAMP_FRAMES, 29'($urandom_range(1, 24)));
            endcase
            calm = (p == 2);
            ch = 0;
            for (int k = 0; k < 154; k++) begin
                // Halfway through, retarget the delay so the glide is exercised.
                if (k == 77) begin
                    drain();
                    write_reg(fdcf_pkg::CFG_DELAY_TARGET,
                              29'($urandom_range(131072, 40 << 16)));
                end
                // Mostly whole frames in channel order, some stray channels.
                if ($urandom_range(9) == 0) begin
                    beat.channel = 3'($urandom_range(7));
                end else begin
                    beat.channel = 3'(ch);
                    ch = (reg_chans == 0 || reg_chans > NCH || ch + 1 >= reg_chans) ?
                         0 : ch + 1;
                end
                beat.sample_in = rand_sample();
                send_beat(beat);
            end
            calm = 1'b0;
        end

        i_in_valid <= 1'b0;
        while (expected_out.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
